// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the queue and back-end modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pfmf_pkg.sv =====
// ----------------------------------------------------------------------------
// pfmf_pkg
// Shared types, constants and helpers of the PIR / frame motion fusion core.
// ----------------------------------------------------------------------------
package pfmf_pkg;

    localparam int COUNT_WIDTH = 32;    // statistics counter width, 8..64
    localparam int SCORE_W     = 16;
    localparam int OUT_CNT_W   = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SCORE_W-1:0] Q_ONE    = 16'd32768;
    localparam logic [SCORE_W-1:0] Q_HALF   = 16'd16384;
    localparam logic [SCORE_W-1:0] Q_BONUS  = 16'd6554;
    localparam logic [SCORE_W-1:0] TH_VHIGH = 16'd29492;
    localparam logic [SCORE_W-1:0] TH_HIGH  = 16'd22938;
    localparam logic [SCORE_W-1:0] TH_MED   = 16'd16384;
    localparam logic [SCORE_W-1:0] TH_LOW   = 16'd6554;

    localparam logic [2:0] LVL_NONE  = 3'd0;
    localparam logic [2:0] LVL_LOW   = 3'd1;
    localparam logic [2:0] LVL_MED   = 3'd2;
    localparam logic [2:0] LVL_HIGH  = 3'd3;
    localparam logic [2:0] LVL_VHIGH = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_POWER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIR_WEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd4;

    // detect modes; code 3 falls back to hybrid
    localparam logic [1:0] MODE_HYBRID = 2'd0;
    localparam logic [1:0] MODE_PIR    = 2'd1;
    localparam logic [1:0] MODE_FRAME  = 2'd2;

    localparam logic OP_EVAL  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [SCORE_W-1:0] PIR_WEIGHT_RST   = 16'd19661;
    localparam logic [SCORE_W-1:0] FRAME_WEIGHT_RST = 16'd13107;

    typedef struct packed {
        logic [1:0]         mode;
        logic               low_power;
        logic [SCORE_W-1:0] pir_weight;
        logic [SCORE_W-1:0] frame_weight;
        logic               enable;
    } t_cfg;

    // what the back end has to do with a queued event
    typedef enum logic [1:0] {
        KIND_NULL  = 2'd0,   // disabled: all-zero result
        KIND_CLEAR = 2'd1,   // zero statistics, all-zero result
        KIND_EVAL  = 2'd2    // fused result, statistics update on motion
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               motion;
        logic [SCORE_W-1:0] score;
        logic [2:0]         level;
        logic               pir_used;
        logic               frame_used;
    } t_entry;

    function automatic logic [2:0] score_level(input logic [SCORE_W-1:0] s);
        logic [2:0] lv;
        if (s >= TH_VHIGH)     lv = LVL_VHIGH;
        else if (s >= TH_HIGH) lv = LVL_HIGH;
        else if (s >= TH_MED)  lv = LVL_MED;
        else if (s >= TH_LOW)  lv = LVL_LOW;
        else                   lv = LVL_NONE;
        return lv;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_CNT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/pfmf_front.sv =====
// ----------------------------------------------------------------------------
// pfmf_front
// Takes events, forms the fused score and classifies them for the back end.
// ----------------------------------------------------------------------------
module pfmf_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_opcode,
    input  logic                           i_pir_motion,
    input  logic                           i_frame_motion,
    input  logic [pfmf_pkg::SCORE_W-1:0]   i_frame_level,
    input  pfmf_pkg::t_cfg                 i_cfg,
    input  logic                           i_full,
    output logic                           o_push,
    output pfmf_pkg::t_entry               o_entry
);

    logic                           r_a_valid;
    logic                           r_a_op;
    logic                           r_a_pir;
    logic                           r_a_frm;
    logic [pfmf_pkg::SCORE_W-1:0]   r_a_lvl;
    logic [2*pfmf_pkg::SCORE_W-1:0] r_a_prod;

    logic       accept;
    logic [17:0] sum;
    logic [17:0] frm_term;

    assign o_stall = r_a_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_a_valid && !i_full;

    // stage A: register event and the weighted frame level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (o_push) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_op   <= i_opcode;
            r_a_pir  <= i_pir_motion;
            r_a_frm  <= i_frame_motion;
            r_a_lvl  <= i_frame_level;
            r_a_prod <= i_cfg.frame_weight * i_frame_level;
        end
    end

    // stage B: fuse and classify
    assign frm_term = 18'(r_a_prod[2*pfmf_pkg::SCORE_W-1:15]);

    always_comb begin
        sum     = 18'(r_a_pir ? i_cfg.pir_weight : '0)
                + (r_a_frm ? frm_term : 18'd0)
                + 18'((r_a_pir && r_a_frm) ? pfmf_pkg::Q_BONUS : '0);
        o_entry = '0;
        if (!i_cfg.enable) begin
            o_entry.kind = pfmf_pkg::KIND_NULL;
        end else if (r_a_op == pfmf_pkg::OP_CLEAR) begin
            o_entry.kind = pfmf_pkg::KIND_CLEAR;
        end else begin
            o_entry.kind = pfmf_pkg::KIND_EVAL;
            if (i_cfg.mode == pfmf_pkg::MODE_PIR) begin
                o_entry.pir_used = r_a_pir;
                o_entry.motion   = r_a_pir;
                o_entry.score    = r_a_pir ? pfmf_pkg::Q_ONE : '0;
            end else if (i_cfg.mode == pfmf_pkg::MODE_FRAME) begin
                o_entry.frame_used = r_a_frm;
                o_entry.motion     = r_a_frm;
                o_entry.score      = (r_a_lvl > pfmf_pkg::Q_ONE) ? pfmf_pkg::Q_ONE : r_a_lvl;
            end else begin
                o_entry.pir_used = r_a_pir;
                if (r_a_pir || !i_cfg.low_power) begin
                    o_entry.frame_used = r_a_frm;
                    o_entry.score      = (sum > 18'(pfmf_pkg::Q_ONE)) ? pfmf_pkg::Q_ONE
                                                                     : sum[15:0];
                    o_entry.motion     = o_entry.score > pfmf_pkg::Q_HALF;
                end
            end
            o_entry.level = pfmf_pkg::score_level(o_entry.score);
        end
    end

endmodule

// ===== rtl/core/pfmf_queue.sv =====
// ----------------------------------------------------------------------------
// pfmf_queue
// Short FIFO of classified events between front and back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfmf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pfmf_pkg::t_entry i_entry,
    input  logic             i_pop,
    output pfmf_pkg::t_entry o_entry,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (pfmf_pkg::QUEUE_DEPTH > 1) ? $clog2(pfmf_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(pfmf_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(pfmf_pkg::QUEUE_DEPTH - 1);

    pfmf_pkg::t_entry r_mem [pfmf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(pfmf_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(pfmf_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

// ===== rtl/core/pfmf_back.sv =====
// ----------------------------------------------------------------------------
// pfmf_back
// Statistics counters, running-mean divider and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfmf_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pfmf_pkg::t_entry                 i_entry,
    input  logic                             i_empty,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_motion,
    output logic [pfmf_pkg::SCORE_W-1:0]     o_score,
    output logic [2:0]                       o_level,
    output logic                             o_pir_used,
    output logic                             o_frame_used,
    output logic [pfmf_pkg::OUT_CNT_W-1:0]   o_total_count,
    output logic [pfmf_pkg::OUT_CNT_W-1:0]   o_pir_only_count,
    output logic [pfmf_pkg::OUT_CNT_W-1:0]   o_frame_only_count,
    output logic [pfmf_pkg::OUT_CNT_W-1:0]   o_both_count,
    output logic [pfmf_pkg::SCORE_W-1:0]     o_mean_confidence
);

    localparam int CW    = pfmf_pkg::COUNT_WIDTH;
    localparam int SW    = pfmf_pkg::SCORE_W;
    localparam int STEPW = $clog2(SW);
    localparam logic [STEPW-1:0] STEP_LAST = STEPW'(SW - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } t_bstate;

    t_bstate          r_state;
    logic [CW-1:0]    r_total;
    logic [CW-1:0]    r_pir;
    logic [CW-1:0]    r_frm;
    logic [CW-1:0]    r_both;
    logic [SW-1:0]    r_mean;

    // divider
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_rem;
    logic [SW-1:0]    r_quo;
    logic [STEPW-1:0] r_step;
    logic             r_up;
    pfmf_pkg::t_entry r_cur;

    logic             r_out_valid;

    logic             out_free;
    logic             load_out;
    logic             is_det;
    logic [SW-1:0]    diff;
    logic [CW:0]      trial;
    logic             fits;
    logic [SW-1:0]    n_mean;
    logic [CW-1:0]    n_total;
    logic [CW-1:0]    n_pir;
    logic [CW-1:0]    n_frm;
    logic [CW-1:0]    n_both;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty && out_free;
    assign is_det   = (i_entry.kind == pfmf_pkg::KIND_EVAL) && i_entry.motion;
    assign load_out = ((r_state == S_IDLE) && o_pop && !is_det)
                    || ((r_state == S_FIN) && out_free);
    assign diff     = (i_entry.score >= r_mean) ? i_entry.score - r_mean
                                                : r_mean - i_entry.score;
    assign trial    = {r_rem, r_quo[SW-1]};
    assign fits     = trial >= {1'b0, r_n};
    assign n_mean   = r_up ? r_mean + r_quo
                           : r_mean - r_quo - SW'(r_rem != '0);

    // category counters, attribution by which sensors were taken in
    always_comb begin
        n_total = pfmf_pkg::sat_inc(r_total);
        n_pir   = r_pir;
        n_frm   = r_frm;
        n_both  = r_both;
        priority if (i_entry.pir_used && !i_entry.frame_used) begin
            n_pir = pfmf_pkg::sat_inc(r_pir);
        end else if (!i_entry.pir_used && i_entry.frame_used) begin
            n_frm = pfmf_pkg::sat_inc(r_frm);
        end else if (i_entry.pir_used && i_entry.frame_used) begin
            n_both = pfmf_pkg::sat_inc(r_both);
        end else begin
            // neither sensor taken in: no category
            n_both = r_both;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_pir       <= '0;
            r_frm       <= '0;
            r_both      <= '0;
            r_mean      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (is_det) begin
                            r_total <= n_total;
                            r_pir   <= n_pir;
                            r_frm   <= n_frm;
                            r_both  <= n_both;
                            r_state <= S_DIV;
                        end else begin
                            if (i_entry.kind == pfmf_pkg::KIND_CLEAR) begin
                                r_total <= '0;
                                r_pir   <= '0;
                                r_frm   <= '0;
                                r_both  <= '0;
                                r_mean  <= '0;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (r_step == STEP_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_mean      <= n_mean;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result valid: set on a load, cleared once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // divider datapath: restoring, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && o_pop) begin
            r_cur  <= i_entry;
            r_n    <= n_total;
            r_rem  <= '0;
            r_quo  <= diff;
            r_up   <= i_entry.score >= r_mean;
            r_step <= '0;
        end else if (r_state == S_DIV) begin
            r_rem  <= fits ? CW'(trial - {1'b0, r_n}) : trial[CW-1:0];
            r_quo  <= {r_quo[SW-2:0], fits};
            r_step <= r_step + STEPW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && o_pop && !is_det) begin
            if (i_entry.kind == pfmf_pkg::KIND_EVAL) begin
                o_motion           <= i_entry.motion;
                o_score            <= i_entry.score;
                o_level            <= i_entry.level;
                o_pir_used         <= i_entry.pir_used;
                o_frame_used       <= i_entry.frame_used;
                o_total_count      <= pfmf_pkg::cnt_out(r_total);
                o_pir_only_count   <= pfmf_pkg::cnt_out(r_pir);
                o_frame_only_count <= pfmf_pkg::cnt_out(r_frm);
                o_both_count       <= pfmf_pkg::cnt_out(r_both);
                o_mean_confidence  <= r_mean;
            end else begin
                o_motion           <= 1'b0;
                o_score            <= '0;
                o_level            <= pfmf_pkg::LVL_NONE;
                o_pir_used         <= 1'b0;
                o_frame_used       <= 1'b0;
                o_total_count      <= '0;
                o_pir_only_count   <= '0;
                o_frame_only_count <= '0;
                o_both_count       <= '0;
                o_mean_confidence  <= '0;
            end
        end else if (r_state == S_FIN && out_free) begin
            o_motion           <= r_cur.motion;
            o_score            <= r_cur.score;
            o_level            <= r_cur.level;
            o_pir_used         <= r_cur.pir_used;
            o_frame_used       <= r_cur.frame_used;
            o_total_count      <= pfmf_pkg::cnt_out(r_total);
            o_pir_only_count   <= pfmf_pkg::cnt_out(r_pir);
            o_frame_only_count <= pfmf_pkg::cnt_out(r_frm);
            o_both_count       <= pfmf_pkg::cnt_out(r_both);
            o_mean_confidence  <= n_mean;
        end
    end

    assign o_valid = r_out_valid;

    `ASSERT_IMPL(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_n != '0, "divide by zero count")
    `ASSERT_ALWAYS(a_mean_range, i_clk, i_rst_n, r_mean <= pfmf_pkg::Q_ONE, "mean above 1.0")
    `ASSERT_ALWAYS(a_total_ge_pir, i_clk, i_rst_n, r_total >= r_pir, "pir count above total")
    `ASSERT_ALWAYS(a_total_ge_both, i_clk, i_rst_n, r_total >= r_both, "both count above total")

endmodule

// ===== rtl/core/pir_frame_motion_fusion.sv =====
// Path: an accepted event is registered in the front end (stage A), fused,
//   pushed into the queue, popped by the back end and loaded into the
//   result register; a motion detection first runs the mean divider.
// Throughput: one item per cycle without motion and no receiver stall; the
//   bit-serial divider in the back end takes no new entry while it is busy.
// Reset (synchronous, active low): statistics zero, registers at defaults.
// ----------------------------------------------------------------------------
// pir_frame_motion_fusion
// Fuses PIR trigger and frame-analysis motion into a score, a confidence
// level and detection statistics with a running mean of the score.
// ----------------------------------------------------------------------------
module pir_frame_motion_fusion (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // event channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_opcode,
    input  logic                                   i_pir_motion,
    input  logic                                   i_frame_motion,
    input  logic [pfmf_pkg::SCORE_W-1:0]           i_frame_level,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_motion,
    output logic [pfmf_pkg::SCORE_W-1:0]           o_score,
    output logic [2:0]                             o_level,
    output logic                                   o_pir_used,
    output logic                                   o_frame_used,
    output logic [pfmf_pkg::OUT_CNT_W-1:0]         o_total_count,
    output logic [pfmf_pkg::OUT_CNT_W-1:0]         o_pir_only_count,
    output logic [pfmf_pkg::OUT_CNT_W-1:0]         o_frame_only_count,
    output logic [pfmf_pkg::OUT_CNT_W-1:0]         o_both_count,
    output logic [pfmf_pkg::SCORE_W-1:0]           o_mean_confidence,
    // register write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pfmf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pfmf_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    pfmf_pkg::t_cfg   r_cfg;
    pfmf_pkg::t_entry front_entry;
    pfmf_pkg::t_entry queue_entry;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;

    // Registers take a write every cycle; software must write only when idle, which the block does not check.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= pfmf_pkg::MODE_HYBRID;
            r_cfg.low_power    <= 1'b0;
            r_cfg.pir_weight   <= pfmf_pkg::PIR_WEIGHT_RST;
            r_cfg.frame_weight <= pfmf_pkg::FRAME_WEIGHT_RST;
            r_cfg.enable       <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pfmf_pkg::REG_DETECT_MODE:  r_cfg.mode         <= i_cfg_data[1:0];
                pfmf_pkg::REG_LOW_POWER:    r_cfg.low_power    <= i_cfg_data[0];
                pfmf_pkg::REG_PIR_WEIGHT:   r_cfg.pir_weight   <= i_cfg_data;
                pfmf_pkg::REG_FRAME_WEIGHT: r_cfg.frame_weight <= i_cfg_data;
                pfmf_pkg::REG_ENABLE:       r_cfg.enable       <= i_cfg_data[0];
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    // Front end: registers the event with the weighted frame level, then
    // fuses and classifies it into a queue entry.
    pfmf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_pir_motion   (i_pir_motion),
        .i_frame_motion (i_frame_motion),
        .i_frame_level  (i_frame_level),
        .i_cfg          (r_cfg),
        .i_full         (q_full),
        .o_push         (push),
        .o_entry        (front_entry)
    );

    // Decouples event intake from the multi-cycle statistics update.
    pfmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (queue_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back end: counters, mean divider and the result register.
    pfmf_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_entry            (queue_entry),
        .i_empty            (q_empty),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_motion           (o_motion),
        .o_score            (o_score),
        .o_level            (o_level),
        .o_pir_used         (o_pir_used),
        .o_frame_used       (o_frame_used),
        .o_total_count      (o_total_count),
        .o_pir_only_count   (o_pir_only_count),
        .o_frame_only_count (o_frame_only_count),
        .o_both_count       (o_both_count),
        .o_mean_confidence  (o_mean_confidence)
    );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PIR / frame motion fusion core. A queue-fed
// driver pushes detection events through the stall handshake in random
// bursts, a scoreboard model predicts every fused result and the detection
// statistics, and a monitor compares each result field by field while the
// receiver stalls on its own pattern. Register settings change only between
// drained phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCORE_W     = pfmf_pkg::SCORE_W;
    localparam int OUT_CNT_W   = pfmf_pkg::OUT_CNT_W;
    localparam int CFG_IDX_W   = pfmf_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = pfmf_pkg::CFG_DATA_W;
    localparam int COUNT_WIDTH = pfmf_pkg::COUNT_WIDTH;

    localparam int CYCLE_LIMIT   = 600000;  // watchdog, well above slowest run
    localparam int TAIL_CYCLES   = 40;      // longer than the motion latency
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_EVENTS  = 113;

    // undefined detect mode code, expected to behave as hybrid
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_RUNS
    } t_stall_mode;

    typedef struct packed {
        logic               op;
        logic               pir;
        logic               frm;
        logic [SCORE_W-1:0] lvl;
    } t_event;

    typedef struct packed {
        logic                 motion;
        logic [SCORE_W-1:0]   score;
        logic [2:0]           level;
        logic                 pir_used;
        logic                 frame_used;
        logic [OUT_CNT_W-1:0] total;
        logic [OUT_CNT_W-1:0] pir_only;
        logic [OUT_CNT_W-1:0] frame_only;
        logic [OUT_CNT_W-1:0] both;
        logic [SCORE_W-1:0]   mean;
    } t_fused;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_stall;
    logic                  i_opcode       = pfmf_pkg::OP_EVAL;
    logic                  i_pir_motion   = 1'b0;
    logic                  i_frame_motion = 1'b0;
    logic [SCORE_W-1:0]    i_frame_level  = '0;
    logic                  o_valid;
    logic                  i_stall        = 1'b0;
    logic                  o_motion;
    logic [SCORE_W-1:0]    o_score;
    logic [2:0]            o_level;
    logic                  o_pir_used;
    logic                  o_frame_used;
    logic [OUT_CNT_W-1:0]  o_total_count;
    logic [OUT_CNT_W-1:0]  o_pir_only_count;
    logic [OUT_CNT_W-1:0]  o_frame_only_count;
    logic [OUT_CNT_W-1:0]  o_both_count;
    logic [SCORE_W-1:0]    o_mean_confidence;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    pir_frame_motion_fusion i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_opcode           (i_opcode),
        .i_pir_motion       (i_pir_motion),
        .i_frame_motion     (i_frame_motion),
        .i_frame_level      (i_frame_level),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_motion           (o_motion),
        .o_score            (o_score),
        .o_level            (o_level),
        .o_pir_used         (o_pir_used),
        .o_frame_used       (o_frame_used),
        .o_total_count      (o_total_count),
        .o_pir_only_count   (o_pir_only_count),
        .o_frame_only_count (o_frame_only_count),
        .o_both_count       (o_both_count),
        .o_mean_confidence  (o_mean_confidence),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_event event_q[$];         // events waiting for the driver
    t_fused fused_q[$];         // predicted results, oldest first

    // shadow copy of the register file
    logic [1:0]         cfg_mode      = pfmf_pkg::MODE_HYBRID;
    logic               cfg_low_power = 1'b0;
    logic [SCORE_W-1:0] cfg_pir_w     = pfmf_pkg::PIR_WEIGHT_RST;
    logic [SCORE_W-1:0] cfg_frame_w   = pfmf_pkg::FRAME_WEIGHT_RST;
    logic               cfg_enable    = 1'b1;

    // shadow copy of the detection statistics
    logic [COUNT_WIDTH-1:0] det_total      = '0;
    logic [COUNT_WIDTH-1:0] det_pir_alone  = '0;
    logic [COUNT_WIDTH-1:0] det_frame_alone = '0;
    logic [COUNT_WIDTH-1:0] det_both       = '0;
    logic [SCORE_W-1:0]     conf_mean      = '0;

    int fail_cnt       = 0;
    int events_taken   = 0;
    int detections_seen = 0;
    int clears_seen    = 0;
    int cfg_writes     = 0;
    int cycle_cnt      = 0;

    // sender burst shaping
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall pattern
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_clock = 0;
    int          stall_run   = 0;
    logic        stall_hold  = 1'b0;

    t_fused exp_r;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d results still outstanding",
                     $time, fused_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard model: fuse one accepted event, update the statistics and
    // queue the expected result
    // ------------------------------------------------------------------------
    task automatic fuse_event(input t_event ev);
        t_fused      r;
        logic [17:0] sum;       // 16b weight + 17b product + bonus fits
        logic [63:0] n;
        logic [63:0] delta;
        r = '0;
        if (cfg_enable) begin
            if (ev.op == pfmf_pkg::OP_CLEAR) begin
                det_total       = '0;
                det_pir_alone   = '0;
                det_frame_alone = '0;
                det_both        = '0;
                conf_mean       = '0;
                clears_seen++;
            end else begin
                case (cfg_mode)
                    pfmf_pkg::MODE_PIR: begin
                        r.pir_used = ev.pir;
                        r.motion   = ev.pir;
                        r.score    = ev.pir ? pfmf_pkg::Q_ONE : '0;
                    end
                    pfmf_pkg::MODE_FRAME: begin
                        r.frame_used = ev.frm;
                        r.motion     = ev.frm;
                        r.score      = (ev.lvl > pfmf_pkg::Q_ONE) ? pfmf_pkg::Q_ONE : ev.lvl;
                    end
                    default: begin
                        // hybrid, and the spare mode code
                        r.pir_used = ev.pir;
                        if (ev.pir || !cfg_low_power) begin
                            r.frame_used = ev.frm;
                            sum = '0;
                            if (ev.pir)
                                sum += 18'(cfg_pir_w);
                            if (ev.frm)
                                sum += 18'((32'(cfg_frame_w) * 32'(ev.lvl)) >> 15);
                            if (ev.pir && ev.frm)
                                sum += 18'(pfmf_pkg::Q_BONUS);
                            r.score  = (sum > 18'(pfmf_pkg::Q_ONE)) ? pfmf_pkg::Q_ONE
                                                                     : sum[SCORE_W-1:0];
                            r.motion = r.score > pfmf_pkg::Q_HALF;
                        end
                    end
                endcase

                if (r.score >= pfmf_pkg::TH_VHIGH)     r.level = pfmf_pkg::LVL_VHIGH;
                else if (r.score >= pfmf_pkg::TH_HIGH) r.level = pfmf_pkg::LVL_HIGH;
                else if (r.score >= pfmf_pkg::TH_MED)  r.level = pfmf_pkg::LVL_MED;
                else if (r.score >= pfmf_pkg::TH_LOW)  r.level = pfmf_pkg::LVL_LOW;
                else                                   r.level = pfmf_pkg::LVL_NONE;

                if (r.motion) begin
                    detections_seen++;
                    if (~&det_total) det_total++;
                    if (r.pir_used && !r.frame_used) begin
                        if (~&det_pir_alone) det_pir_alone++;
                    end else if (!r.pir_used && r.frame_used) begin
                        if (~&det_frame_alone) det_frame_alone++;
                    end else if (r.pir_used && r.frame_used) begin
                        if (~&det_both) det_both++;
                    end
                    // running mean: floor of the exact new mean, so a step
                    // down rounds its magnitude up
                    n = 64'(det_total);
                    if (r.score >= conf_mean) begin
                        delta     = 64'(r.score - conf_mean);
                        conf_mean = conf_mean + SCORE_W'(delta / n);
                    end else begin
                        delta     = 64'(conf_mean - r.score);
                        conf_mean = conf_mean - SCORE_W'((delta + n - 1) / n);
                    end
                end

                r.total      = OUT_CNT_W'(det_total);
                r.pir_only   = OUT_CNT_W'(det_pir_alone);
                r.frame_only = OUT_CNT_W'(det_frame_alone);
                r.both       = OUT_CNT_W'(det_both);
                r.mean       = conf_mean;
            end
        end
        fused_q.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents queued events in bursts with random gaps. A stalled
    // transaction is held untouched; prediction happens on acceptance.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                fuse_event('{i_opcode, i_pir_motion, i_frame_motion, i_frame_level});
                void'(event_q.pop_front());
                events_taken++;
            end
            if (gap_left != 0 || event_q.size() == 0) begin
                if (gap_left != 0) gap_left--;
                i_valid <= 1'b0;
            end else begin
                i_valid        <= 1'b1;
                i_opcode       <= event_q[0].op;
                i_pir_motion   <= event_q[0].pir;
                i_frame_motion <= event_q[0].frm;
                i_frame_level  <= event_q[0].lvl;
                if (burst_left <= 1) begin
                    // about a third of the bursts run back to back
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall: pattern is redrawn at regular intervals from none,
    // random, periodic and long runs
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        stall_clock++;
        if (stall_clock % 300 == 0)
            stall_mode = t_stall_mode'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:     i_stall <= 1'b0;
            STALL_RANDOM:   i_stall <= ($urandom_range(0, 99) < 35);
            STALL_PERIODIC: i_stall <= ((stall_clock % 7) < 3);
            default: begin
                if (stall_run == 0) begin
                    stall_run  = $urandom_range(1, 24);
                    stall_hold = ~stall_hold;
                end else begin
                    stall_run--;
                end
                i_stall <= stall_hold;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted result against the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (fused_q.size() == 0) begin
                $display("%0t: result with nothing expected (score %0d)", $time, o_score);
                fail_cnt++;
            end else begin
                exp_r = fused_q.pop_front();
                check_field("motion",           exp_r.motion,     o_motion);
                check_field("score",            exp_r.score,      o_score);
                check_field("level",            exp_r.level,      o_level);
                check_field("pir_used",         exp_r.pir_used,   o_pir_used);
                check_field("frame_used",       exp_r.frame_used, o_frame_used);
                check_field("total_count",      exp_r.total,      o_total_count);
                check_field("pir_only_count",   exp_r.pir_only,   o_pir_only_count);
                check_field("frame_only_count", exp_r.frame_only, o_frame_only_count);
                check_field("both_count",       exp_r.both,       o_both_count);
                check_field("mean_confidence",  exp_r.mean,       o_mean_confidence);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            pfmf_pkg::REG_DETECT_MODE:  cfg_mode      = data[1:0];
            pfmf_pkg::REG_LOW_POWER:    cfg_low_power = data[0];
            pfmf_pkg::REG_PIR_WEIGHT:   cfg_pir_w     = data;
            pfmf_pkg::REG_FRAME_WEIGHT: cfg_frame_w   = data;
            pfmf_pkg::REG_ENABLE:       cfg_enable    = data[0];
            default: ;        // out of range: ignored by the block too
        endcase
        cfg_writes++;
    endtask

    // wait until every queued event is accepted and every result is back
    task automatic drain();
        while (event_q.size() != 0 || fused_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic push_event(input logic op, input logic pir, input logic frm,
                              input logic [SCORE_W-1:0] lvl);
        event_q.push_back('{op, pir, frm, lvl});
    endtask

    task automatic push_random(input int count);
        t_event             ev;
        int                 pick;
        logic [SCORE_W-1:0] mark;
        for (int k = 0; k < count; k++) begin
            ev.op  = ($urandom_range(0, 39) == 0) ? pfmf_pkg::OP_CLEAR : pfmf_pkg::OP_EVAL;
            ev.pir = $urandom_range(0, 1);
            ev.frm = $urandom_range(0, 1);
            case ($urandom_range(0, 6))
                0:       mark = '0;
                1:       mark = pfmf_pkg::TH_LOW;
                2:       mark = pfmf_pkg::TH_MED;
                3:       mark = pfmf_pkg::TH_HIGH;
                4:       mark = pfmf_pkg::TH_VHIGH;
                5:       mark = pfmf_pkg::Q_ONE;
                default: mark = '1;
            endcase
            pick = $urandom_range(0, 3);
            case (pick)
                0:       ev.lvl = SCORE_W'($urandom);
                1:       ev.lvl = SCORE_W'($urandom_range(0, int'(pfmf_pkg::Q_ONE)));
                2:       ev.lvl = mark + SCORE_W'($urandom_range(0, 4)) - SCORE_W'(2);
                default: ev.lvl = mark;
            endcase
            event_q.push_back(ev);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [1:0]         mode;
        logic [SCORE_W-1:0] pw;
        logic [SCORE_W-1:0] fw;
        logic [SCORE_W-1:0] junk;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // --- directed: reset defaults, hybrid fusion ---
        push_event(pfmf_pkg::OP_EVAL,  1'b0, 1'b0, 16'd0);           // nothing fired
        push_event(pfmf_pkg::OP_EVAL,  1'b1, 1'b1, pfmf_pkg::Q_ONE); // both + bonus, clamps
        push_event(pfmf_pkg::OP_EVAL,  1'b1, 1'b0, 16'd0);           // PIR alone, 0.6
        push_event(pfmf_pkg::OP_EVAL,  1'b0, 1'b1, pfmf_pkg::Q_ONE); // frame alone, 0.4
        push_event(pfmf_pkg::OP_EVAL,  1'b0, 1'b1, 16'hFFFF);        // level above 1.0
        push_event(pfmf_pkg::OP_EVAL,  1'b1, 1'b1, 16'd0);           // bonus on zero level
        push_event(pfmf_pkg::OP_CLEAR, 1'b1, 1'b1, 16'hFFFF);        // statistics cleared
        drain();

        // --- directed: PIR only ---
        set_reg(pfmf_pkg::REG_DETECT_MODE, {14'd0, pfmf_pkg::MODE_PIR});
        push_event(pfmf_pkg::OP_EVAL, 1'b1, 1'b1, 16'd5);
        push_event(pfmf_pkg::OP_EVAL, 1'b0, 1'b1, pfmf_pkg::Q_ONE);
        drain();

        // --- directed: frame only, level extremes and thresholds ---
        set_reg(pfmf_pkg::REG_DETECT_MODE, {14'd0, pfmf_pkg::MODE_FRAME});
        push_event(pfmf_pkg::OP_EVAL, 1'b0, 1'b1, 16'd0);
        push_event(pfmf_pkg::OP_EVAL, 1'b1, 1'b0, pfmf_pkg::Q_ONE);
        push_event(pfmf_pkg::OP_EVAL, 1'b0, 1'b1, pfmf_pkg::Q_ONE + 16'd1);
        push_event(pfmf_pkg::OP_EVAL, 1'b1, 1'b1, 16'hFFFF);
        push_event(pfmf_pkg::OP_EVAL, 1'b0, 1'b1, pfmf_pkg::TH_VHIGH);
        push_event(pfmf_pkg::OP_EVAL, 1'b0, 1'b1, pfmf_pkg::TH_HIGH);
        push_event(pfmf_pkg::OP_EVAL, 1'b0, 1'b1, pfmf_pkg::TH_MED);
        push_event(pfmf_pkg::OP_EVAL, 1'b0, 1'b0, pfmf_pkg::TH_LOW);
        push_event(pfmf_pkg::OP_EVAL, 1'b0, 1'b1, pfmf_pkg::TH_LOW - 16'd1);
        drain();

        // --- directed: spare mode code with low power ---
        set_reg(pfmf_pkg::REG_DETECT_MODE, {14'd0, MODE_SPARE});
        set_reg(pfmf_pkg::REG_LOW_POWER, 16'd1);
        push_event(pfmf_pkg::OP_EVAL, 1'b0, 1'b1, pfmf_pkg::Q_ONE);  // frame skipped, no PIR
        push_event(pfmf_pkg::OP_EVAL, 1'b1, 1'b1, 16'd100);
        drain();

        // --- directed: weights far above 1.0 ---
        set_reg(pfmf_pkg::REG_LOW_POWER, 16'd0);
        set_reg(pfmf_pkg::REG_PIR_WEIGHT, 16'hFFFF);
        set_reg(pfmf_pkg::REG_FRAME_WEIGHT, 16'hFFFF);
        push_event(pfmf_pkg::OP_EVAL, 1'b1, 1'b1, 16'hFFFF);
        drain();

        // --- directed: disabled, statistics must hold through a clear ---
        set_reg(pfmf_pkg::REG_ENABLE, 16'd0);
        push_event(pfmf_pkg::OP_EVAL,  1'b1, 1'b1, pfmf_pkg::Q_ONE);
        push_event(pfmf_pkg::OP_CLEAR, 1'b0, 1'b0, 16'd0);
        drain();
        set_reg(pfmf_pkg::REG_ENABLE, 16'd1);
        // out-of-range indexes carry zero data; a bad decode would disable
        for (int k = int'(pfmf_pkg::REG_ENABLE) + 1; k < (1 << CFG_IDX_W); k++)
            set_reg(CFG_IDX_W'(k), 16'd0);
        push_event(pfmf_pkg::OP_EVAL, 1'b1, 1'b0, 16'd0);
        drain();

        // --- random phases, one register setting each ---
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 5)
                1:       mode = pfmf_pkg::MODE_PIR;
                3:       mode = pfmf_pkg::MODE_FRAME;
                4:       mode = MODE_SPARE;
                default: mode = pfmf_pkg::MODE_HYBRID;
            endcase
            case ($urandom_range(0, 5))
                0: begin pw = pfmf_pkg::PIR_WEIGHT_RST; fw = pfmf_pkg::FRAME_WEIGHT_RST; end
                1: begin
                    pw = SCORE_W'($urandom_range(0, int'(pfmf_pkg::Q_ONE)));
                    fw = pfmf_pkg::Q_ONE - pw;
                end
                2: begin pw = '0;              fw = pfmf_pkg::Q_ONE; end
                3: begin pw = pfmf_pkg::Q_ONE; fw = '0;              end
                4: begin pw = SCORE_W'($urandom); fw = SCORE_W'($urandom); end
                default: begin                 // PIR alone sits at 0.5
                    pw = pfmf_pkg::Q_HALF;
                    fw = pfmf_pkg::Q_HALF;
                end
            endcase
            // unused upper data bits carry junk; only the low bits count
            junk = SCORE_W'($urandom);
            set_reg(pfmf_pkg::REG_DETECT_MODE, {junk[15:2], mode});
            junk = SCORE_W'($urandom);
            set_reg(pfmf_pkg::REG_LOW_POWER, {junk[15:1], 1'($urandom_range(0, 1))});
            set_reg(pfmf_pkg::REG_PIR_WEIGHT, pw);
            set_reg(pfmf_pkg::REG_FRAME_WEIGHT, fw);
            junk = SCORE_W'($urandom);
            set_reg(pfmf_pkg::REG_ENABLE, {junk[15:1], (p != 6)});

            if (p == 6) begin
                push_random(20);
            end else begin
                push_random(PHASE_EVENTS / 2);
                // in phase 0 and about a third of the rest, the sender holds off until the block is fully drained
                if (p == 0 || $urandom_range(0, 2) == 0)
                    drain();
                push_random(PHASE_EVENTS - PHASE_EVENTS / 2);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fused_q.size() != 0) begin
            $display("%0t: %0d predicted results never arrived", $time, fused_q.size());
            fail_cnt++;
        end

        $display("Run covered %0d events with %0d detections and %0d clears, %0d register writes",
                 events_taken, detections_seen, clears_seen, cfg_writes);
        $display("Modes hybrid, PIR, frame and spare code; low power, heavy weights, disabled");
        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", fail_cnt);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
